/* design/vdpc_pkg.sv */
// shared types, constants and the arctangent table of the docking controller
package vdpc_pkg;

    // cordic angle accumulator, q.20 radians
    localparam int ZW = 24;
    // heading angle after rounding, q3.12 radians
    localparam int ANGLE_W = 16;

    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    // reciprocal of the cordic gain, q.16
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_TOL_X       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TOL_Y       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_LIMIT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_GAIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_GAIN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LINEAR  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ANGULAR = 3'd6;

    typedef enum logic [1:0] {
        ST_WAITING     = 2'd0,
        ST_APPROACHING = 2'd1,
        ST_ARRIVED     = 2'd2
    } vdpc_status_t;

    // travels alongside each item through the pipeline
    typedef struct packed {
        logic         valid;
        vdpc_status_t status;
        logic         zero;
    } vdpc_tag_t;

    typedef struct packed {
        logic [14:0] tol_x;
        logic [14:0] tol_y;
        logic [13:0] angle_limit;
        logic [15:0] turn_gain;
        logic [15:0] drive_gain;
        logic [14:0] max_linear;
        logic [14:0] max_angular;
    } vdpc_cfg_t;

    typedef struct packed {
        vdpc_status_t       status;
        logic signed [15:0] turn;
        logic [14:0]        drive;
    } vdpc_result_t;

    // atan(2^-i) in q.20 radians, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q20(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 24'sd823550;
            1:       v = 24'sd486170;
            2:       v = 24'sd256879;
            3:       v = 24'sd130396;
            4:       v = 24'sd65451;
            5:       v = 24'sd32757;
            6:       v = 24'sd16383;
            7:       v = 24'sd8192;
            8:       v = 24'sd4096;
            9:       v = 24'sd2048;
            10:      v = 24'sd1024;
            11:      v = 24'sd512;
            12:      v = 24'sd256;
            13:      v = 24'sd128;
            14:      v = 24'sd64;
            15:      v = 24'sd32;
            16:      v = 24'sd16;
            17:      v = 24'sd8;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/visual_docking_p_controller.sv */
// visual docking controller top level: front end, cordic chain, post stages, output queue
//
// One pose item in on the s_ stream, one command item out on the m_ stream.
// s_tuser carries the pose-valid flag; s_tdata carries the pose x and y.
// Items with no pose give zero commands and status waiting; items inside
// the arrival box give zero commands and status arrived; the rest go through
// a vectoring cordic for heading and distance and are scaled by the gains.
// Throughput: one item per cycle while the output queue is not full, set by the
// pipelined chain of cordic cells. An accepted item passes through the front
// register, one register per cordic cell, three post stages and the output
// register before m_tvalid. Configuration must be written through
// cfg_we/cfg_addr/cfg_wdata only while idle, a rule for the user that the
// block does not enforce. Indexes beyond the register list are ignored.
// Reset clears the pipeline and output queue and loads the default gains,
// tolerances and limits. When the receiver stalls, a two-entry output queue
// keeps taking results; the pipeline and s_tready hold only once both
// entries are full, so a single waiting result does not block new items.
module visual_docking_p_controller #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 14
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // pose x forward, pose y lateral, zero fill
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    // pose_valid
    input  logic [0:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // drive_cmd, turn_cmd, zero fill
    output logic [31:0]                                 m_tdata,
    // approach_status
    output logic [1:0]                                  m_tuser,
    input  logic                                        cfg_we,
    input  logic [vdpc_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [vdpc_pkg::CFG_DATA_W-1:0]             cfg_wdata
);
    import vdpc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int XW    = COORD_WIDTH + 11;
    localparam int CMP_W = (COORD_WIDTH + 1 > 16) ? COORD_WIDTH + 1 : 16;

    vdpc_cfg_t            cfg_reg;

    logic                 en;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW:0]   sxe;
    logic signed [CW:0]   sye;
    logic [CW:0]          ax;
    logic [CW:0]          ay;
    logic                 arrived;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] x0_next;
    logic signed [XW-1:0] y0_next;
    logic signed [ZW-1:0] z0_next;
    vdpc_tag_t            tag0_next;
    vdpc_tag_t            tag0_reg;
    logic signed [XW-1:0] x0_reg;
    logic signed [XW-1:0] y0_reg;
    logic signed [ZW-1:0] z0_reg;

    vdpc_tag_t            tag_c [0:CORDIC_STAGES];
    logic signed [XW-1:0] x_c   [0:CORDIC_STAGES];
    logic signed [XW-1:0] y_c   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_c   [0:CORDIC_STAGES];

    logic                 res_valid;
    vdpc_result_t         res;
    logic                 push;
    logic                 pop;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    vdpc_result_t         out_data_reg;
    vdpc_result_t         skid_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tol_x       <= 15'd61;
            cfg_reg.tol_y       <= 15'd164;
            cfg_reg.angle_limit <= 14'd2130;
            cfg_reg.turn_gain   <= 16'd4915;
            cfg_reg.drive_gain  <= 16'd1638;
            cfg_reg.max_linear  <= 15'd492;
            cfg_reg.max_angular <= 15'd1229;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TOL_X:       cfg_reg.tol_x       <= cfg_wdata[14:0];
                REG_TOL_Y:       cfg_reg.tol_y       <= cfg_wdata[14:0];
                REG_ANGLE_LIMIT: cfg_reg.angle_limit <= cfg_wdata[13:0];
                REG_TURN_GAIN:   cfg_reg.turn_gain   <= cfg_wdata;
                REG_DRIVE_GAIN:  cfg_reg.drive_gain  <= cfg_wdata;
                REG_MAX_LINEAR:  cfg_reg.max_linear  <= cfg_wdata[14:0];
                REG_MAX_ANGULAR: cfg_reg.max_angular <= cfg_wdata[14:0];
                default:         ;
            endcase
        end
    end

    // front end: arrival box, scaling by 256 and quadrant pre-rotation
    always_comb
    begin
        sx      = $signed(s_tdata[CW-1:0]);
        sy      = $signed(s_tdata[2*CW-1:CW]);
        sxe     = {sx[CW-1], sx};
        sye     = {sy[CW-1], sy};
        ax      = sxe[CW] ? (CW+1)'(-sxe) : (CW+1)'(sxe);
        ay      = sye[CW] ? (CW+1)'(-sye) : (CW+1)'(sye);
        arrived = (CMP_W'(ax) < CMP_W'(cfg_reg.tol_x)) && (CMP_W'(ay) < CMP_W'(cfg_reg.tol_y));
        xs      = {{3{sx[CW-1]}}, sx, 8'd0};
        ys      = {{3{sy[CW-1]}}, sy, 8'd0};

        if (xs[XW-1])
        begin
            if (!ys[XW-1])
            begin
                x0_next = ys;
                y0_next = -xs;
                z0_next = HALF_PI_Q20;
            end
            else
            begin
                x0_next = -ys;
                y0_next = xs;
                z0_next = -HALF_PI_Q20;
            end
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            z0_next = '0;
        end

        tag0_next.valid = s_tvalid;
        tag0_next.zero  = (sx == '0) && (sy == '0);
        if (!s_tuser[0])
            tag0_next.status = ST_WAITING;
        else if (arrived)
            tag0_next.status = ST_ARRIVED;
        else
            tag0_next.status = ST_APPROACHING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
        end
        else if (en)
        begin
            tag0_reg <= tag0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= z0_next;
        end
    end

    assign tag_c[0] = tag0_reg;
    assign x_c[0]   = x0_reg;
    assign y_c[0]   = y0_reg;
    assign z_c[0]   = z0_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        vdpc_cordic_cell #(
            .XY_W  (XW),
            .STAGE (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tag_in  (tag_c[i]),
            .x_in    (x_c[i]),
            .y_in    (y_c[i]),
            .z_in    (z_c[i]),
            .tag_out (tag_c[i+1]),
            .x_out   (x_c[i+1]),
            .y_out   (y_c[i+1]),
            .z_out   (z_c[i+1])
        );
    end

    vdpc_post #(
        .XY_W (XW)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .tag_in    (tag_c[CORDIC_STAGES]),
        .x_in      (x_c[CORDIC_STAGES]),
        .z_in      (z_c[CORDIC_STAGES]),
        .res_valid (res_valid),
        .res       (res)
    );

    // two-entry output queue: output register plus skid entry
    assign en   = !skid_valid_reg;
    assign push = en && res_valid;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg)
        begin
            if (pop && !push)
                out_valid_reg <= 1'b0;
            else if (!pop && push)
                skid_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= res;
            else
                out_data_reg <= res;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.turn, out_data_reg.drive};
    assign m_tuser  = out_data_reg.status;

endmodule

/* design/vdpc_cordic_cell.sv */
// one vectoring cordic micro-rotation with its pipeline register
module vdpc_cordic_cell #(
    parameter int XY_W  = 27,
    parameter int STAGE = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  vdpc_pkg::vdpc_tag_t              tag_in,
    input  logic signed [XY_W-1:0]           x_in,
    input  logic signed [XY_W-1:0]           y_in,
    input  logic signed [vdpc_pkg::ZW-1:0]   z_in,
    output vdpc_pkg::vdpc_tag_t              tag_out,
    output logic signed [XY_W-1:0]           x_out,
    output logic signed [XY_W-1:0]           y_out,
    output logic signed [vdpc_pkg::ZW-1:0]   z_out
);
    import vdpc_pkg::*;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   y_pos;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [ZW-1:0]   z_next;
    vdpc_tag_t              tag_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [ZW-1:0]   z_reg;

    always_comb
    begin
        dx    = y_in >>> STAGE;
        dy    = x_in >>> STAGE;
        y_pos = !y_in[XY_W-1] && (y_in != '0);
        if (y_pos)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_q20(STAGE);
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_q20(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

/* design/vdpc_post.sv */
// distance scaling, gain multiplies and command saturation after the cordic
module vdpc_post #(
    parameter int XY_W = 27
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  vdpc_pkg::vdpc_cfg_t             cfg,
    input  vdpc_pkg::vdpc_tag_t             tag_in,
    input  logic signed [XY_W-1:0]          x_in,
    input  logic signed [vdpc_pkg::ZW-1:0]  z_in,
    output logic                            res_valid,
    output vdpc_pkg::vdpc_result_t          res
);
    import vdpc_pkg::*;

    localparam int XH_W = XY_W - 16;
    localparam int PH_W = XH_W + 17;
    localparam int PW   = XY_W + 17;
    localparam int DW   = PW - 24;
    localparam int DP_W = DW + 17;
    localparam int TP_W = ANGLE_W + 17;
    localparam int TV_W = TP_W - 12;
    localparam int DV_W = DP_W - 12;

    // stage 1: angle rounding, distance partial products
    logic signed [XY_W-1:0]    x_sel;
    logic signed [ZW-1:0]      z_round;
    logic [31:0]               p_lo_next;
    logic signed [PH_W-1:0]    p_hi_next;
    logic signed [ANGLE_W-1:0] angle1_next;
    vdpc_tag_t                 tag1_reg;
    logic [31:0]               p_lo_reg;
    logic signed [PH_W-1:0]    p_hi_reg;
    logic signed [ANGLE_W-1:0] angle1_reg;

    // stage 2: distance sum, heading gate
    logic [PW-1:0]             dist_sum;
    logic [ANGLE_W-1:0]        angle_mag;
    logic signed [DW-1:0]      dist2_next;
    logic                      gate2_next;
    vdpc_tag_t                 tag2_reg;
    logic signed [DW-1:0]      dist2_reg;
    logic signed [ANGLE_W-1:0] angle2_reg;
    logic                      gate2_reg;

    // stage 3: gain products
    logic signed [TP_W-1:0]    turn_p_next;
    logic signed [DP_W-1:0]    drive_p_next;
    vdpc_tag_t                 tag3_reg;
    logic signed [TP_W-1:0]    turn_p_reg;
    logic signed [DP_W-1:0]    drive_p_reg;
    logic                      gate3_reg;

    // rounding and saturation
    logic [TP_W-1:0]           turn_round;
    logic [DP_W-1:0]           drive_round;
    logic signed [TV_W-1:0]    turn_val;
    logic signed [DV_W-1:0]    drive_val;
    logic signed [TV_W-1:0]    max_ang;
    logic signed [DV_W-1:0]    max_lin;
    logic signed [TV_W-1:0]    turn_clamp;
    logic signed [DV_W-1:0]    drive_clamp;

    always_comb
    begin
        x_sel       = tag_in.zero ? '0 : x_in;
        z_round     = z_in + ZW'(128);
        angle1_next = tag_in.zero ? '0 : z_round[ZW-1:8];
        p_lo_next   = 32'(x_sel[15:0]) * 32'(INV_GAIN_Q16);
        p_hi_next   = PH_W'($signed(x_sel[XY_W-1:16])) * PH_W'($signed({1'b0, INV_GAIN_Q16}));
    end

    always_comb
    begin
        dist_sum   = (PW'(p_hi_reg) << 16) + PW'(p_lo_reg) + PW'(1 << 23);
        dist2_next = $signed(dist_sum[PW-1:24]);
        angle_mag  = angle1_reg[ANGLE_W-1] ? 16'(-angle1_reg) : 16'(angle1_reg);
        gate2_next = angle_mag > {2'b00, cfg.angle_limit};
    end

    always_comb
    begin
        turn_p_next  = TP_W'($signed({1'b0, cfg.turn_gain})) * TP_W'(angle2_reg);
        drive_p_next = DP_W'($signed({1'b0, cfg.drive_gain})) * DP_W'(dist2_reg);
    end

    always_comb
    begin
        turn_round  = turn_p_reg + TP_W'(2048);
        drive_round = drive_p_reg + DP_W'(2048);
        turn_val    = $signed(turn_round[TP_W-1:12]);
        drive_val   = $signed(drive_round[DP_W-1:12]);
        max_ang     = TV_W'($signed({1'b0, cfg.max_angular}));
        max_lin     = DV_W'($signed({1'b0, cfg.max_linear}));

        if (turn_val > max_ang)
            turn_clamp = max_ang;
        else if (turn_val < -max_ang)
            turn_clamp = -max_ang;
        else
            turn_clamp = turn_val;

        if (gate3_reg || drive_val[DV_W-1])
            drive_clamp = '0;
        else if (drive_val > max_lin)
            drive_clamp = max_lin;
        else
            drive_clamp = drive_val;

        res_valid  = tag3_reg.valid;
        res.status = tag3_reg.status;
        if (tag3_reg.status == ST_APPROACHING)
        begin
            res.turn  = turn_clamp[15:0];
            res.drive = drive_clamp[14:0];
        end
        else
        begin
            res.turn  = '0;
            res.drive = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            angle1_reg  <= angle1_next;
            dist2_reg   <= dist2_next;
            angle2_reg  <= angle1_reg;
            gate2_reg   <= gate2_next;
            turn_p_reg  <= turn_p_next;
            drive_p_reg <= drive_p_next;
            gate3_reg   <= gate2_reg;
        end
    end

endmodule
